// ===== src/abp_pkg.sv =====
// abp_pkg: shared types and constants for the box overlap pair search.
// Depends on nothing; every module of the block uses it by scoped names.
`default_nettype none
package abp_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
   localparam int SLOT_W     = 3;
   localparam int COORD_W    = 16;

   typedef struct packed {
      logic                       present;
      logic                       fixed_obj;
      logic signed [COORD_W-1:0]  box_min_x;
      logic signed [COORD_W-1:0]  box_min_y;
      logic signed [COORD_W-1:0]  box_max_x;
      logic signed [COORD_W-1:0]  box_max_y;
      logic                       last_object;
   } req_type;

   typedef struct packed {
      logic                       present;
      logic                       fixed_obj;
      logic signed [COORD_W-1:0]  box_min_x;
      logic signed [COORD_W-1:0]  box_min_y;
      logic signed [COORD_W-1:0]  box_max_x;
      logic signed [COORD_W-1:0]  box_max_y;
   } slot_type;

   typedef struct packed {
      logic              pair_valid;
      logic [SLOT_W-1:0] first_slot;
      logic [SLOT_W-1:0] second_slot;
      logic              last_pair;
      logic              overflow;
   } rsp_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      slot_type         data;
   } wr_type;

   typedef struct packed {
      logic    load;
      rsp_type data;
   } emit_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_FLUSH
   } state_type;

endpackage
`default_nettype wire

// ===== src/aabb_broad_phase_pairs.sv =====
// An item not marked last is taken with no result.
// The item marked last starts a scan of n(n-1)/2 pairs over the n loaded slots,
// each pair read from memory and then put through the shared overlap test; a
// flush state releases the final result. Input stalls for the whole scan.
// Reset clears the fill count, overflow flag and output valid; slots are not cleared.
`default_nettype none
module aabb_broad_phase_pairs (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  abp_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output abp_pkg::rsp_type  rsp_data
);

   abp_pkg::wr_type           wr;
   logic [abp_pkg::IDX_W-1:0] rd_addr_a;
   logic [abp_pkg::IDX_W-1:0] rd_addr_b;
   abp_pkg::slot_type         rd_data_a;
   abp_pkg::slot_type         rd_data_b;
   logic                      hit;
   logic                      out_free;
   abp_pkg::emit_type         emit;

   logic                      rsp_valid_ff, rsp_valid_in;
   abp_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   abp_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .wr        (wr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .hit       (hit),
      .out_free  (out_free),
      .emit      (emit)
   );

   abp_store u_store (
      .clock     (clock),
      .wr        (wr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   abp_overlap u_overlap (
      .a   (rd_data_a),
      .b   (rd_data_b),
      .hit (hit)
   );

   // output register: load on free slot, drop valid after transfer
   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (emit.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== src/abp_store.sv =====
// abp_store: object slot memory, one write port and two registered read ports.
// Depends on abp_pkg.
`default_nettype none
module abp_store (
   input  wire                      clock,
   input  abp_pkg::wr_type          wr,
   input  wire [abp_pkg::IDX_W-1:0] rd_addr_a,
   input  wire [abp_pkg::IDX_W-1:0] rd_addr_b,
   output abp_pkg::slot_type        rd_data_a,
   output abp_pkg::slot_type        rd_data_b
);

   abp_pkg::slot_type mem [abp_pkg::SLOT_COUNT];
   abp_pkg::slot_type rd_a_ff;
   abp_pkg::slot_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

// ===== src/abp_overlap.sv =====
// abp_overlap: shared pair test unit, existence, static filter and box overlap.
// Depends on abp_pkg.
`default_nettype none
module abp_overlap (
   input  abp_pkg::slot_type a,
   input  abp_pkg::slot_type b,
   output logic              hit
);

   logic sep_x;
   logic sep_y;

   always_comb begin
      sep_x = (a.box_min_x > b.box_max_x) || (a.box_max_x < b.box_min_x);
      sep_y = (a.box_min_y > b.box_max_y) || (a.box_max_y < b.box_min_y);
      hit   = a.present && b.present && !(a.fixed_obj && b.fixed_obj) && !sep_x && !sep_y;
   end

endmodule
`default_nettype wire

// ===== src/abp_seq.sv =====
// abp_seq: slot loader and pair scan sequencer with one pending result.
// Depends on abp_pkg; drives abp_store and consumes the abp_overlap result.
`default_nettype none
module abp_seq (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   input  abp_pkg::req_type          req_data,
   output logic                      req_stall,
   output abp_pkg::wr_type           wr,
   output logic [abp_pkg::IDX_W-1:0] rd_addr_a,
   output logic [abp_pkg::IDX_W-1:0] rd_addr_b,
   input  wire                       hit,
   input  wire                       out_free,
   output abp_pkg::emit_type         emit
);

   abp_pkg::state_type        state_ff, state_in;
   logic [abp_pkg::CNT_W-1:0] fill_ff, fill_in;
   logic                      ovf_ff, ovf_in;
   logic [abp_pkg::IDX_W-1:0] i_ff, i_in;
   logic [abp_pkg::IDX_W-1:0] j_ff, j_in;
   logic                      pend_ff, pend_in;
   logic [abp_pkg::IDX_W-1:0] pend_i_ff, pend_i_in;
   logic [abp_pkg::IDX_W-1:0] pend_j_ff, pend_j_in;

   logic                      accept;
   logic                      has_room;
   logic [abp_pkg::CNT_W-1:0] fill_next;
   logic                      last_j;
   logic                      done;
   logic                      hold;

   always_comb begin
      accept    = (state_ff == abp_pkg::ST_IDLE) && req_valid;
      has_room  = fill_ff < abp_pkg::CNT_W'(abp_pkg::SLOT_COUNT);
      fill_next = has_room ? fill_ff + abp_pkg::CNT_W'(1) : fill_ff;
      last_j    = (abp_pkg::CNT_W'(j_ff) + abp_pkg::CNT_W'(1)) == fill_ff;
      done      = last_j && ((abp_pkg::CNT_W'(i_ff) + abp_pkg::CNT_W'(2)) >= fill_ff);
      hold      = hit && pend_ff && !out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         abp_pkg::ST_IDLE: begin
            if (req_valid && req_data.last_object) begin
               state_in = (fill_next < abp_pkg::CNT_W'(2)) ? abp_pkg::ST_FLUSH
                                                            : abp_pkg::ST_READ;
            end
         end
         abp_pkg::ST_READ: begin
            state_in = abp_pkg::ST_EVAL;
         end
         abp_pkg::ST_EVAL: begin
            if (!hold) begin
               state_in = done ? abp_pkg::ST_FLUSH : abp_pkg::ST_READ;
            end
         end
         abp_pkg::ST_FLUSH: begin
            if (out_free) begin
               state_in = abp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = abp_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall = state_ff != abp_pkg::ST_IDLE;
      rd_addr_a = i_ff;
      rd_addr_b = j_ff;

      wr.en     = accept && has_room;
      wr.addr   = fill_ff[abp_pkg::IDX_W-1:0];
      wr.data   = '{present:   req_data.present,
                    fixed_obj: req_data.fixed_obj,
                    box_min_x: req_data.box_min_x,
                    box_min_y: req_data.box_min_y,
                    box_max_x: req_data.box_max_x,
                    box_max_y: req_data.box_max_y};

      emit.load             = 1'b0;
      emit.data.pair_valid  = pend_ff;
      emit.data.first_slot  = pend_ff ? abp_pkg::SLOT_W'(pend_i_ff) : '0;
      emit.data.second_slot = pend_ff ? abp_pkg::SLOT_W'(pend_j_ff) : '0;
      emit.data.last_pair   = 1'b0;
      emit.data.overflow    = ovf_ff;

      fill_in   = fill_ff;
      ovf_in    = ovf_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      pend_in   = pend_ff;
      pend_i_in = pend_i_ff;
      pend_j_in = pend_j_ff;

      unique case (state_ff)
         abp_pkg::ST_IDLE: begin
            if (accept) begin
               fill_in = fill_next;
               ovf_in  = ovf_ff || !has_room;
               i_in    = '0;
               j_in    = abp_pkg::IDX_W'(1);
               pend_in = 1'b0;
            end
         end
         abp_pkg::ST_READ: begin
         end
         abp_pkg::ST_EVAL: begin
            if (!hold) begin
               if (hit) begin
                  emit.load = pend_ff;
                  pend_in   = 1'b1;
                  pend_i_in = i_ff;
                  pend_j_in = j_ff;
               end
               if (last_j) begin
                  i_in = i_ff + abp_pkg::IDX_W'(1);
                  j_in = i_ff + abp_pkg::IDX_W'(2);
               end else begin
                  j_in = j_ff + abp_pkg::IDX_W'(1);
               end
            end
         end
         abp_pkg::ST_FLUSH: begin
            emit.data.last_pair = 1'b1;
            if (out_free) begin
               emit.load = 1'b1;
               fill_in   = '0;
               ovf_in    = 1'b0;
               pend_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= abp_pkg::ST_IDLE;
         fill_ff  <= '0;
         ovf_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         ovf_ff   <= ovf_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      pend_i_ff <= pend_i_in;
      pend_j_ff <= pend_j_in;
   end

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= abp_pkg::CNT_W'(abp_pkg::SLOT_COUNT))
      else $error("fill count beyond slot count");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == abp_pkg::ST_READ || state_ff == abp_pkg::ST_EVAL)
      |-> (i_ff < j_ff) && (abp_pkg::CNT_W'(j_ff) < fill_ff))
      else $error("scan pair out of range");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == abp_pkg::ST_FLUSH && out_free)
      |=> (fill_ff == '0) && !ovf_ff && !pend_ff && state_ff == abp_pkg::ST_IDLE)
      else $error("frame state not cleared after search");

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      emit.load |-> out_free && (pend_ff || state_ff == abp_pkg::ST_FLUSH))
      else $error("result transfer without room or without pending pair");
`endif

endmodule
`default_nettype wire

// ===== test/tb_aabb_broad_phase_pairs.sv =====
`timescale 1ns / 100ps
// tb_aabb_broad_phase_pairs: frame-based test of the box overlap pair search.
// Predicts every pair from its own slot copy and checks each result transfer in order.
// Depends on abp_pkg and aabb_broad_phase_pairs from src.
module tb_aabb_broad_phase_pairs;

   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 310;
   localparam int DRAIN_CYCLES = 64;

   typedef struct {
      bit      present;
      bit      fixed_obj;
      shortint lo_x;
      shortint lo_y;
      shortint hi_x;
      shortint hi_y;
   } body_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   abp_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   abp_pkg::rsp_type rsp_data;

   body_type         frame_bodies[abp_pkg::SLOT_COUNT];
   int unsigned      frame_fill;
   bit               frame_dropped;
   abp_pkg::rsp_type expected_pairs[$];
   int               mismatch_count;
   bit               idling_off;
   int               items_sent;

   aabb_broad_phase_pairs dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
   end

   function automatic bit bodies_touch(body_type a, body_type b);
      if (a.lo_x > b.hi_x || a.hi_x < b.lo_x) return 1'b0;
      if (a.lo_y > b.hi_y || a.hi_y < b.lo_y) return 1'b0;
      return 1'b1;
   endfunction

   // Load a slot or flag overflow; on a last item queue every hit or an empty result.
   function automatic void predict_pairs(abp_pkg::req_type item);
      abp_pkg::rsp_type r;
      int               found;
      found = 0;
      if (frame_fill < abp_pkg::SLOT_COUNT) begin
         frame_bodies[frame_fill].present   = item.present;
         frame_bodies[frame_fill].fixed_obj = item.fixed_obj;
         frame_bodies[frame_fill].lo_x      = item.box_min_x;
         frame_bodies[frame_fill].lo_y      = item.box_min_y;
         frame_bodies[frame_fill].hi_x      = item.box_max_x;
         frame_bodies[frame_fill].hi_y      = item.box_max_y;
         frame_fill++;
      end else begin
         frame_dropped = 1'b1;
      end
      if (!item.last_object) return;
      for (int i = 0; i < frame_fill; i++) begin
         if (!frame_bodies[i].present) continue;
         for (int j = i + 1; j < frame_fill; j++) begin
            if (!frame_bodies[j].present) continue;
            if (frame_bodies[i].fixed_obj && frame_bodies[j].fixed_obj) continue;
            if (!bodies_touch(frame_bodies[i], frame_bodies[j])) continue;
            r.pair_valid  = 1'b1;
            r.first_slot  = i[abp_pkg::SLOT_W-1:0];
            r.second_slot = j[abp_pkg::SLOT_W-1:0];
            r.last_pair   = 1'b0;
            r.overflow    = frame_dropped;
            expected_pairs.push_back(r);
            found++;
         end
      end
      if (found == 0) begin
         r.pair_valid  = 1'b0;
         r.first_slot  = '0;
         r.second_slot = '0;
         r.last_pair   = 1'b1;
         r.overflow    = frame_dropped;
         expected_pairs.push_back(r);
      end else begin
         expected_pairs[expected_pairs.size()-1].last_pair = 1'b1;
      end
      frame_fill    = 0;
      frame_dropped = 1'b0;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      abp_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pairs.size() == 0) begin
            $error("unexpected result transfer: pair_valid %0d first_slot %0d second_slot %0d",
                   rsp_data.pair_valid, rsp_data.first_slot, rsp_data.second_slot);
            mismatch_count++;
         end else begin
            want = expected_pairs.pop_front();
            check_field("pair_valid", want.pair_valid, rsp_data.pair_valid);
            check_field("first_slot", want.first_slot, rsp_data.first_slot);
            check_field("second_slot", want.second_slot, rsp_data.second_slot);
            check_field("last_pair", want.last_pair, rsp_data.last_pair);
            check_field("overflow", want.overflow, rsp_data.overflow);
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (!idling_off && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   function automatic abp_pkg::req_type make_item(bit present, bit fixed_obj, int lx, int ly,
                                                  int hx, int hy, bit last_object);
      abp_pkg::req_type item;
      item.present     = present;
      item.fixed_obj   = fixed_obj;
      item.box_min_x   = lx[abp_pkg::COORD_W-1:0];
      item.box_min_y   = ly[abp_pkg::COORD_W-1:0];
      item.box_max_x   = hx[abp_pkg::COORD_W-1:0];
      item.box_max_y   = hy[abp_pkg::COORD_W-1:0];
      item.last_object = last_object;
      return item;
   endfunction

   // Mostly boxes on a coarse grid so that overlaps and touching edges are common.
   function automatic abp_pkg::req_type random_item(bit last_object);
      abp_pkg::req_type item;
      int               cx, cy, wx, wy;
      if ($urandom_range(0, 4) == 0) begin
         item.box_min_x = abp_pkg::COORD_W'($urandom);
         item.box_min_y = abp_pkg::COORD_W'($urandom);
         item.box_max_x = abp_pkg::COORD_W'($urandom);
         item.box_max_y = abp_pkg::COORD_W'($urandom);
         item.present   = $urandom_range(0, 1) != 0;
         item.fixed_obj = $urandom_range(0, 1) != 0;
      end else begin
         cx   = 64 * $urandom_range(0, 30) - 960;
         cy   = 64 * $urandom_range(0, 30) - 960;
         wx   = 64 * $urandom_range(0, 8);
         wy   = 64 * $urandom_range(0, 8);
         item = make_item($urandom_range(0, 7) != 0, $urandom_range(0, 2) == 0,
                          cx - wx, cy - wy, cx + wx, cy + wy, 1'b0);
      end
      item.last_object = last_object;
      return item;
   endfunction

   task automatic send_item(abp_pkg::req_type item);
      if (!idling_off && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predict_pairs(item);
      items_sent++;
   endtask

   task automatic test_lone_object();
      send_item(make_item(1'b1, 1'b0, -100, -100, 100, 100, 1'b1));
   endtask

   task automatic test_all_overlap();
      for (int k = 0; k < abp_pkg::SLOT_COUNT; k++)
         send_item(make_item(1'b1, k == 3, -32768, -32768, 32767, 32767,
                             k == abp_pkg::SLOT_COUNT - 1));
   endtask

   task automatic test_edge_cases();
      send_item(make_item(1'b1, 1'b0, 0, 0, 100, 100, 1'b0));
      send_item(make_item(1'b1, 1'b0, 100, 100, 200, 200, 1'b0));
      send_item(make_item(1'b1, 1'b1, 101, 0, 200, 100, 1'b0));
      send_item(make_item(1'b1, 1'b1, 150, 50, 300, 90, 1'b0));
      send_item(make_item(1'b0, 1'b0, -32768, -32768, 32767, 32767, 1'b0));
      send_item(make_item(1'b1, 1'b0, -32768, 32767, 32767, -32768, 1'b1));
   endtask

   task automatic test_overflow();
      for (int k = 0; k < abp_pkg::SLOT_COUNT + 2; k++)
         send_item(random_item(k == abp_pkg::SLOT_COUNT + 1));
   endtask

   task automatic test_random_frames();
      int frame_len;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent > RANDOM_ITEMS - 50) idling_off = 1'b1;
         if ($urandom_range(0, 6) == 0)
            frame_len = $urandom_range(abp_pkg::SLOT_COUNT + 1, abp_pkg::SLOT_COUNT + 3);
         else frame_len = $urandom_range(1, abp_pkg::SLOT_COUNT);
         for (int k = 0; k < frame_len; k++)
            send_item(random_item(k == frame_len - 1));
      end
   endtask

   initial begin
      frame_fill     = 0;
      frame_dropped  = 1'b0;
      mismatch_count = 0;
      idling_off     = 1'b0;
      items_sent     = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_lone_object();
      test_all_overlap();
      test_edge_cases();
      test_overflow();
      test_random_frames();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_pairs.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_pairs.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
